// ===== hdl/psd_pkg.sv =====
// shared types and constants of the packet stream deframer
package psd_pkg;

	localparam int BYTE_W  = 8;
	localparam int KIND_W  = 4;
	localparam int VALUE_W = 32;
	localparam int CFG_W   = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_W-1:0] HANDSHAKE_CODE_RST = 8'd1;
	localparam logic [CFG_W-1:0] MESSAGE_CODE_RST   = 8'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HANDSHAKE_CODE = 1'b0,
		REG_MESSAGE_CODE   = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_MSG_LEN   = 4'd1,
		PH_MSG_BODY  = 4'd2,
		PH_PORT      = 4'd3,
		PH_ID_LEN    = 4'd4,
		PH_ID_BODY   = 4'd5,
		PH_KEY_LEN   = 4'd6,
		PH_KEY_BODY  = 4'd7,
		PH_NODE_CNT  = 4'd8,
		PH_NODE_ADDR = 4'd9,
		PH_NODE_PORT = 4'd10
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_MSG_LEN   = 4'd0,
		KIND_MSG_BYTE  = 4'd1,
		KIND_PORT      = 4'd2,
		KIND_ID_LEN    = 4'd3,
		KIND_ID_BYTE   = 4'd4,
		KIND_KEY_LEN   = 4'd5,
		KIND_KEY_BYTE  = 4'd6,
		KIND_NODE_CNT  = 4'd7,
		KIND_NODE_ADDR = 4'd8,
		KIND_NODE_PORT = 4'd9,
		KIND_BAD_TYPE  = 4'd10
	} kind_t;

	typedef struct packed {
		logic                valid;
		logic [KIND_W-1:0]   kind;
		logic [VALUE_W-1:0]  value;
		logic                packet_end;
	} result_t;

endpackage

// ===== hdl/psd_stream_if.sv =====
// stream channel interfaces for input bytes and decoded results
interface psd_byte_if;
	import psd_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface psd_result_if;
	import psd_pkg::*;

	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [VALUE_W-1:0] value;
	logic               packet_end;

	modport source (output valid, output kind, output value, output packet_end, input ready);
	modport sink (input valid, input kind, input value, input packet_end, output ready);
endinterface

// ===== hdl/packet_stream_deframer_top.sv =====
// packet stream deframer top level with configuration registers and result register
//
// The block takes one stream byte per cycle and gives at most one result per byte, in the
// cycle after the byte's transfer, from a single result register. A byte is taken in any
// cycle in which the result register is empty or its result is being taken in the same
// cycle, so a steady stream runs at one byte per clock; the only stall comes from the
// result side. Matched type bytes and partial multi-byte fields give no result, other type
// bytes a bad-type result. The user must write the type codes through the configuration
// port while idle (the block does not enforce it); they are used only on a type byte.
module packet_stream_deframer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	psd_byte_if.sink                       bytes,
	psd_result_if.source                   results,
	input  logic                           cfg_we,
	input  logic [psd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psd_pkg::CFG_W-1:0]      cfg_data
);
	import psd_pkg::*;

	logic [CFG_W-1:0]   handshake_code_q;
	logic [CFG_W-1:0]   message_code_q;
	logic               take;
	result_t            res;
	logic               out_valid_q;
	logic [KIND_W-1:0]  kind_q;
	logic [VALUE_W-1:0] value_q;
	logic               packet_end_q;

	assign bytes.ready = !out_valid_q || results.ready;
	assign take        = bytes.valid && bytes.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			handshake_code_q <= HANDSHAKE_CODE_RST;
			message_code_q   <= MESSAGE_CODE_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_HANDSHAKE_CODE: handshake_code_q <= cfg_data;
				REG_MESSAGE_CODE:   message_code_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	psd_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.in_byte        (bytes.in_byte),
		.handshake_code (handshake_code_q),
		.message_code   (message_code_q),
		.res            (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (bytes.ready) begin
			out_valid_q <= take && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res.valid) begin
			kind_q       <= res.kind;
			value_q      <= res.value;
			packet_end_q <= res.packet_end;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.kind       = kind_q;
	assign results.value      = value_q;
	assign results.packet_end = packet_end_q;

endmodule

// ===== hdl/psd_parser.sv =====
// packet parse state machine with field assembly and length counters
module psd_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic [psd_pkg::BYTE_W-1:0]  in_byte,
	input  logic [psd_pkg::CFG_W-1:0]   handshake_code,
	input  logic [psd_pkg::CFG_W-1:0]   message_code,
	output psd_pkg::result_t            res
);
	import psd_pkg::*;

	phase_t             phase_q, phase_nxt;
	logic [1:0]         byte_cnt_q;
	logic [VALUE_W-1:0] acc_q;
	logic [VALUE_W-1:0] bytes_rem_q;
	logic [VALUE_W-1:0] nodes_rem_q;

	logic [1:0]         last_idx;
	logic               field_done;
	logic               is_field;
	logic [VALUE_W-1:0] acc_shift;
	logic [VALUE_W-1:0] port_value;
	logic [VALUE_W-1:0] byte_value;
	logic [VALUE_W-1:0] rem_dec;
	logic [VALUE_W-1:0] nodes_dec;
	logic               len_zero;
	logic               hs_hit;
	logic               msg_hit;

	assign last_idx   = (phase_q == PH_PORT || phase_q == PH_NODE_PORT) ? 2'd1 : 2'd3;
	assign field_done = (byte_cnt_q == last_idx);
	assign is_field   = (phase_q == PH_MSG_LEN) || (phase_q == PH_PORT) ||
		(phase_q == PH_ID_LEN) || (phase_q == PH_KEY_LEN) || (phase_q == PH_NODE_CNT) ||
		(phase_q == PH_NODE_ADDR) || (phase_q == PH_NODE_PORT);
	assign acc_shift  = {acc_q[VALUE_W-BYTE_W-1:0], in_byte};
	assign port_value = {16'h0000, acc_shift[15:0]};
	assign byte_value = {{(VALUE_W-BYTE_W){1'b0}}, in_byte};
	assign rem_dec    = bytes_rem_q - 32'd1;
	assign nodes_dec  = nodes_rem_q - 32'd1;
	assign len_zero   = (acc_shift == '0);
	assign hs_hit     = (in_byte == handshake_code);
	assign msg_hit    = (in_byte == message_code);

	// next phase
	always_comb begin
		phase_nxt = phase_q;
		unique case (phase_q)
			PH_MSG_LEN: begin
				if (field_done) phase_nxt = len_zero ? PH_IDLE : PH_MSG_BODY;
			end
			PH_MSG_BODY: begin
				if (rem_dec == '0) phase_nxt = PH_IDLE;
			end
			PH_PORT: begin
				if (field_done) phase_nxt = PH_ID_LEN;
			end
			PH_ID_LEN: begin
				if (field_done) phase_nxt = len_zero ? PH_KEY_LEN : PH_ID_BODY;
			end
			PH_ID_BODY: begin
				if (rem_dec == '0) phase_nxt = PH_KEY_LEN;
			end
			PH_KEY_LEN: begin
				if (field_done) phase_nxt = len_zero ? PH_NODE_CNT : PH_KEY_BODY;
			end
			PH_KEY_BODY: begin
				if (rem_dec == '0) phase_nxt = PH_NODE_CNT;
			end
			PH_NODE_CNT: begin
				if (field_done) phase_nxt = len_zero ? PH_IDLE : PH_NODE_ADDR;
			end
			PH_NODE_ADDR: begin
				if (field_done) phase_nxt = PH_NODE_PORT;
			end
			PH_NODE_PORT: begin
				if (field_done) phase_nxt = (nodes_dec == '0) ? PH_IDLE : PH_NODE_ADDR;
			end
			default: begin
				if (hs_hit) phase_nxt = PH_PORT;
				else if (msg_hit) phase_nxt = PH_MSG_LEN;
				else phase_nxt = PH_IDLE;
			end
		endcase
	end

	// result for the byte being taken
	always_comb begin
		res = '0;
		unique case (phase_q)
			PH_MSG_LEN: begin
				res.valid = field_done;
				res.kind = KIND_MSG_LEN;
				res.value = acc_shift;
				res.packet_end = len_zero;
			end
			PH_MSG_BODY: begin
				res.valid = 1'b1;
				res.kind = KIND_MSG_BYTE;
				res.value = byte_value;
				res.packet_end = (rem_dec == '0);
			end
			PH_PORT: begin
				res.valid = field_done;
				res.kind = KIND_PORT;
				res.value = port_value;
			end
			PH_ID_LEN: begin
				res.valid = field_done;
				res.kind = KIND_ID_LEN;
				res.value = acc_shift;
			end
			PH_ID_BODY: begin
				res.valid = 1'b1;
				res.kind = KIND_ID_BYTE;
				res.value = byte_value;
			end
			PH_KEY_LEN: begin
				res.valid = field_done;
				res.kind = KIND_KEY_LEN;
				res.value = acc_shift;
			end
			PH_KEY_BODY: begin
				res.valid = 1'b1;
				res.kind = KIND_KEY_BYTE;
				res.value = byte_value;
			end
			PH_NODE_CNT: begin
				res.valid = field_done;
				res.kind = KIND_NODE_CNT;
				res.value = acc_shift;
				res.packet_end = len_zero;
			end
			PH_NODE_ADDR: begin
				res.valid = field_done;
				res.kind = KIND_NODE_ADDR;
				res.value = acc_shift;
			end
			PH_NODE_PORT: begin
				res.valid = field_done;
				res.kind = KIND_NODE_PORT;
				res.value = port_value;
				res.packet_end = (nodes_dec == '0);
			end
			default: begin
				res.valid = !hs_hit && !msg_hit;
				res.kind = KIND_BAD_TYPE;
				res.value = byte_value;
				res.packet_end = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			byte_cnt_q  <= '0;
			acc_q       <= '0;
			bytes_rem_q <= '0;
			nodes_rem_q <= '0;
		end else if (take) begin
			phase_q <= phase_nxt;
			if (is_field) begin
				if (field_done) begin
					byte_cnt_q <= '0;
					acc_q      <= '0;
				end else begin
					byte_cnt_q <= byte_cnt_q + 2'd1;
					acc_q      <= acc_shift;
				end
			end
			unique case (phase_q)
				PH_MSG_LEN, PH_ID_LEN, PH_KEY_LEN: begin
					if (field_done) bytes_rem_q <= acc_shift;
				end
				PH_MSG_BODY, PH_ID_BODY, PH_KEY_BODY: begin
					bytes_rem_q <= rem_dec;
				end
				PH_NODE_CNT: begin
					if (field_done) nodes_rem_q <= acc_shift;
				end
				PH_NODE_PORT: begin
					if (field_done) nodes_rem_q <= nodes_dec;
				end
				PH_PORT, PH_NODE_ADDR: begin
				end
				default: begin
					byte_cnt_q <= '0;
					acc_q      <= '0;
				end
			endcase
		end
	end

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the packet stream deframer: byte stream in, decoded fields out
module testbench;
	import psd_pkg::*;

	typedef struct packed {
		kind_t              kind;
		logic [VALUE_W-1:0] value;
		logic               packet_end;
	} field_result_t;

	class deframer_scoreboard;
		logic [CFG_W-1:0]   hs_code;
		logic [CFG_W-1:0]   msg_code;
		phase_t             ph;
		logic [2:0]         nbytes;
		logic [VALUE_W-1:0] acc;
		logic [VALUE_W-1:0] remaining;
		logic [VALUE_W-1:0] nodes;
		field_result_t      awaited[$];
		int                 errors;

		function new();
			hs_code = HANDSHAKE_CODE_RST;
			msg_code = MESSAGE_CODE_RST;
			ph = PH_IDLE;
			nbytes = 0;
			acc = 0;
			remaining = 0;
			nodes = 0;
			errors = 0;
		endfunction

		function void set_code(reg_idx_t idx, logic [CFG_W-1:0] v);
			if (idx == REG_HANDSHAKE_CODE) begin
				hs_code = v;
			end else begin
				msg_code = v;
			end
		endfunction

		// shift one byte into the field, true once n bytes are in
		function bit shift_in(logic [7:0] b, int n);
			acc = {acc[23:0], b};
			nbytes = nbytes + 3'd1;
			if (nbytes >= n) begin
				nbytes = 0;
				return 1;
			end
			return 0;
		endfunction

		function bit decode_byte(logic [7:0] b, output field_result_t r);
			logic [VALUE_W-1:0] f;
			r = '0;
			case (ph)
				PH_MSG_LEN: begin
					if (!shift_in(b, 4)) return 0;
					f = acc;
					acc = 0;
					remaining = f;
					ph = (f == 0) ? PH_IDLE : PH_MSG_BODY;
					r = '{kind: KIND_MSG_LEN, value: f, packet_end: (f == 0)};
					return 1;
				end
				PH_MSG_BODY: begin
					remaining = remaining - 1;
					if (remaining == 0) ph = PH_IDLE;
					r = '{kind: KIND_MSG_BYTE, value: {24'd0, b}, packet_end: (remaining == 0)};
					return 1;
				end
				PH_PORT: begin
					if (!shift_in(b, 2)) return 0;
					f = {16'd0, acc[15:0]};
					acc = 0;
					ph = PH_ID_LEN;
					r = '{kind: KIND_PORT, value: f, packet_end: 1'b0};
					return 1;
				end
				PH_ID_LEN: begin
					if (!shift_in(b, 4)) return 0;
					f = acc;
					acc = 0;
					remaining = f;
					ph = (f == 0) ? PH_KEY_LEN : PH_ID_BODY;
					r = '{kind: KIND_ID_LEN, value: f, packet_end: 1'b0};
					return 1;
				end
				PH_ID_BODY: begin
					remaining = remaining - 1;
					if (remaining == 0) ph = PH_KEY_LEN;
					r = '{kind: KIND_ID_BYTE, value: {24'd0, b}, packet_end: 1'b0};
					return 1;
				end
				PH_KEY_LEN: begin
					if (!shift_in(b, 4)) return 0;
					f = acc;
					acc = 0;
					remaining = f;
					ph = (f == 0) ? PH_NODE_CNT : PH_KEY_BODY;
					r = '{kind: KIND_KEY_LEN, value: f, packet_end: 1'b0};
					return 1;
				end
				PH_KEY_BODY: begin
					remaining = remaining - 1;
					if (remaining == 0) ph = PH_NODE_CNT;
					r = '{kind: KIND_KEY_BYTE, value: {24'd0, b}, packet_end: 1'b0};
					return 1;
				end
				PH_NODE_CNT: begin
					if (!shift_in(b, 4)) return 0;
					f = acc;
					acc = 0;
					nodes = f;
					ph = (f == 0) ? PH_IDLE : PH_NODE_ADDR;
					r = '{kind: KIND_NODE_CNT, value: f, packet_end: (f == 0)};
					return 1;
				end
				PH_NODE_ADDR: begin
					if (!shift_in(b, 4)) return 0;
					f = acc;
					acc = 0;
					ph = PH_NODE_PORT;
					r = '{kind: KIND_NODE_ADDR, value: f, packet_end: 1'b0};
					return 1;
				end
				PH_NODE_PORT: begin
					if (!shift_in(b, 2)) return 0;
					f = {16'd0, acc[15:0]};
					acc = 0;
					nodes = nodes - 1;
					ph = (nodes == 0) ? PH_IDLE : PH_NODE_ADDR;
					r = '{kind: KIND_NODE_PORT, value: f, packet_end: (nodes == 0)};
					return 1;
				end
				default: begin
					nbytes = 0;
					acc = 0;
					// handshake wins when both codes match
					if (b == hs_code) begin
						ph = PH_PORT;
						return 0;
					end
					if (b == msg_code) begin
						ph = PH_MSG_LEN;
						return 0;
					end
					ph = PH_IDLE;
					r = '{kind: KIND_BAD_TYPE, value: {24'd0, b}, packet_end: 1'b1};
					return 1;
				end
			endcase
		endfunction

		function void note_byte(logic [7:0] b);
			field_result_t r;
			if (decode_byte(b, r)) awaited = {awaited, r};
		endfunction

		function void check_result(field_result_t got);
			field_result_t want;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: unexpected result kind %0d value %h end %b",
					$time, got.kind, got.value, got.packet_end);
				return;
			end
			want = awaited.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: expected kind %0d value %h end %b, got kind %0d value %h end %b",
					$time, want.kind, want.value, want.packet_end,
					got.kind, got.value, got.packet_end);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	psd_byte_if   byte_ch();
	psd_result_if res_ch();

	packet_stream_deframer_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytes     (byte_ch),
		.results   (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	deframer_scoreboard sb;
	deframer_scoreboard stream_plan;
	logic [7:0]         pkt_q[$];
	logic [7:0]         stream_q[$];
	bit                 send_burst;
	bit                 take_burst;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("testbench: FAIL");
		$finish;
	end

	function automatic int draw_gap(ref bit burst);
		if ($urandom_range(0, 63) == 0) burst = !burst;
		return burst ? 0 : int'($urandom_range(0, 12));
	endfunction

	function automatic logic [31:0] draw_word(int bits);
		logic [31:0] mask;
		mask = (bits == 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return mask;
			default: return $urandom & mask;
		endcase
	endfunction

	function automatic int draw_len();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0) return $urandom_range(48, 160);
		if (r < 4) return 0;
		return $urandom_range(1, 12);
	endfunction

	function automatic void add_field(logic [31:0] v, int n);
		for (int i = n - 1; i >= 0; i--) pkt_q = {pkt_q, v[8*i +: 8]};
	endfunction

	function automatic void feed(logic [7:0] b);
		field_result_t r;
		void'(stream_plan.decode_byte(b, r));
		stream_q = {stream_q, b};
	endfunction

	function automatic void feed_first(int n);
		for (int i = 0; i < n; i++) feed(pkt_q[i]);
	endfunction

	task automatic send_byte(logic [7:0] b);
		int gap;
		@(negedge clk);
		gap = draw_gap(send_burst);
		if (gap > 0) begin
			byte_ch.valid = 0;
			repeat (gap) @(negedge clk);
		end
		byte_ch.valid = 1;
		byte_ch.in_byte = b;
		do @(posedge clk); while (!byte_ch.ready);
		sb.note_byte(b);
	endtask

	task automatic write_code(reg_idx_t idx, logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 0;
		sb.set_code(idx, v);
		stream_plan.set_code(idx, v);
	endtask

	task automatic wait_idle();
		int n;
		n = 0;
		while (sb.awaited.size() != 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		repeat (4) @(negedge clk);
	endtask

	// result side: random stalls plus two long hold-offs to back up the input
	initial begin
		int gap;
		int taken;
		field_result_t got;
		res_ch.ready = 0;
		taken = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (taken == 150 || taken == 900) begin
				res_ch.ready = 0;
				repeat ($urandom_range(200, 400)) @(negedge clk);
			end
			gap = draw_gap(take_burst);
			if (gap > 0) begin
				res_ch.ready = 0;
				repeat (gap) @(negedge clk);
			end
			res_ch.ready = 1;
			do @(posedge clk); while (!res_ch.valid);
			got.kind = kind_t'(res_ch.kind);
			got.value = res_ch.value;
			got.packet_end = res_ch.packet_end;
			sb.check_result(got);
			taken++;
		end
	end

	initial begin
		int pick;
		int cut;
		int len;
		int n;
		logic [7:0] b;
		logic [CFG_W-1:0] hs;
		logic [CFG_W-1:0] ms;
		sb = new();
		stream_plan = new();
		send_burst = 0;
		take_burst = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_HANDSHAKE_CODE;
		cfg_data = 0;
		byte_ch.valid = 0;
		byte_ch.in_byte = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		for (int round = 0; round < 6; round++) begin
			if (round > 0) begin
				wait_idle();
				case (round)
					1: begin hs = 8'h00; ms = 8'hFF; end
					2: begin hs = 8'hFF; ms = 8'h00; end
					3: begin hs = 8'h07; ms = 8'h07; end
					default: begin
						hs = 8'($urandom_range(0, 255));
						ms = 8'($urandom_range(0, 255));
					end
				endcase
				write_code(REG_HANDSHAKE_CODE, hs);
				write_code(REG_MESSAGE_CODE, ms);
			end else begin
				// empty message, one-byte message, bad types, all-empty handshake
				pkt_q.delete();
				add_field(32'(stream_plan.msg_code), 1);
				add_field(0, 4);
				add_field(32'(stream_plan.msg_code), 1);
				add_field(1, 4);
				add_field(32'(8'hFF), 1);
				add_field(32'(8'hFF), 1);
				add_field(32'(8'h00), 1);
				add_field(32'(stream_plan.hs_code), 1);
				add_field(32'(16'hFFFF), 2);
				add_field(0, 4);
				add_field(0, 4);
				add_field(0, 4);
				feed_first(pkt_q.size());
			end

			while (stream_q.size() < 275) begin
				pick = $urandom_range(0, 99);
				if (pick < 10) begin
					do b = 8'($urandom_range(0, 255));
					while (b == stream_plan.hs_code || b == stream_plan.msg_code);
					feed(b);
				end else if (pick < 18) begin
					feed(8'($urandom_range(0, 255)));
				end else begin
					pkt_q.delete();
					if (pick < 55 && stream_plan.msg_code != stream_plan.hs_code) begin
						add_field(32'(stream_plan.msg_code), 1);
						len = draw_len();
						add_field(len, 4);
						repeat (len) add_field($urandom_range(0, 255), 1);
					end else begin
						add_field(32'(stream_plan.hs_code), 1);
						add_field(draw_word(16), 2);
						len = draw_len();
						add_field(len, 4);
						repeat (len) add_field($urandom_range(0, 255), 1);
						len = draw_len();
						add_field(len, 4);
						repeat (len) add_field($urandom_range(0, 255), 1);
						len = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 12)
							: $urandom_range(0, 4);
						add_field(len, 4);
						repeat (len) begin
							add_field(draw_word(32), 4);
							add_field(draw_word(16), 2);
						end
					end
					cut = pkt_q.size();
					if ($urandom_range(0, 11) == 0) cut = $urandom_range(1, pkt_q.size() - 1);
					feed_first(cut);
				end
				// zero bytes bring a broken or stray packet back to the type byte
				n = 0;
				while (stream_plan.ph != PH_IDLE && n < 512) begin
					feed(8'h00);
					n++;
				end
			end

			while (stream_q.size() != 0) send_byte(stream_q.pop_front());
			@(negedge clk);
			byte_ch.valid = 0;
		end

		wait_idle();
		if (sb.awaited.size() != 0) begin
			sb.errors++;
			$display("%0t: %0d expected results never arrived", $time, sb.awaited.size());
		end
		if (sb.errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end
endmodule
